>>> hw/rtl/dpbc_pkg.sv
// Package for the debounced pulse burst counter.
// Holds the item, result and configuration types, the register indexes and the reset values.
// Has no dependencies.
package dpbc_pkg;

	localparam int CFG_W = 16;
	localparam int TIME_W = 32;
	localparam int CNT_W = 32;

	// Register indexes on the configuration port
	localparam logic CFG_MIN_PULSE_WIDTH = 1'b0;
	localparam logic CFG_MAX_PULSE_GAP = 1'b1;

	// Item mode codes
	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_W-1:0] MIN_PULSE_WIDTH_RST = 16'd10;
	localparam logic [CFG_W-1:0] MAX_PULSE_GAP_RST = 16'd500;

	typedef struct packed {
		logic [CFG_W-1:0] min_pulse_width;
		logic [CFG_W-1:0] max_pulse_gap;
	} cfg_t;

	typedef struct packed {
		logic              mode;
		logic              pin_level;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  total_pulses;
		logic [CNT_W-1:0]  run_pulses;
		logic [TIME_W-1:0] high_width_ms;
	} result_t;

endpackage

>>> hw/rtl/dpbc_cfg.sv
// Configuration registers of the debounced pulse burst counter.
// Depends on dpbc_pkg.
module dpbc_cfg
	import dpbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_width <= MIN_PULSE_WIDTH_RST;
			cfg_q.max_pulse_gap <= MAX_PULSE_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_PULSE_WIDTH: cfg_q.min_pulse_width <= cfg_data;
				CFG_MAX_PULSE_GAP:   cfg_q.max_pulse_gap <= cfg_data;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/dpbc_engine.sv
// Edge state and status logic of the debounced pulse burst counter.
// Updates the edge and count state for one item and forms its status. Depends on dpbc_pkg.
module dpbc_engine
	import dpbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic              rising_q;
	logic [TIME_W-1:0] edge_time_q;
	logic [TIME_W-1:0] pulse_end_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  total_q;

	logic              rising_d;
	logic [TIME_W-1:0] edge_time_d;
	logic [TIME_W-1:0] pulse_end_d;
	logic [CNT_W-1:0]  run_d;
	logic [CNT_W-1:0]  total_d;

	logic [TIME_W-1:0] edge_span;
	logic [TIME_W-1:0] stat_span;
	logic [TIME_W-1:0] min_w;
	logic [TIME_W-1:0] max_g;

	assign min_w = {{(TIME_W-CFG_W){1'b0}}, cfg.min_pulse_width};
	assign max_g = {{(TIME_W-CFG_W){1'b0}}, cfg.max_pulse_gap};
	assign edge_span = item.now_ms - edge_time_q;

	always_comb begin
		rising_d = rising_q;
		edge_time_d = edge_time_q;
		pulse_end_d = pulse_end_q;
		run_d = run_q;
		total_d = total_q;
		// repeated level and queries leave the state alone
		if (item.mode == MODE_EDGE && item.pin_level != rising_q) begin
			rising_d = item.pin_level;
			if (item.pin_level) begin
				if (edge_span > max_g) run_d = '0;
				edge_time_d = item.now_ms;
			end else if (edge_span < min_w) begin
				// bounce: fall back to the end of the last good pulse
				edge_time_d = pulse_end_q;
			end else begin
				run_d = run_q + 1'b1;
				total_d = total_q + 1'b1;
				edge_time_d = item.now_ms;
				pulse_end_d = item.now_ms;
			end
		end
	end

	assign stat_span = item.now_ms - edge_time_d;

	always_comb begin
		result.total_pulses = total_d;
		if (rising_d) begin
			result.run_pulses = run_d;
			result.high_width_ms = (stat_span < min_w) ? '0 : stat_span;
		end else begin
			result.run_pulses = (stat_span > max_g) ? '0 : run_d;
			result.high_width_ms = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_q <= 1'b0;
			edge_time_q <= '0;
			pulse_end_q <= '0;
			run_q <= '0;
			total_q <= '0;
		end else if (en) begin
			rising_q <= rising_d;
			edge_time_q <= edge_time_d;
			pulse_end_q <= pulse_end_d;
			run_q <= run_d;
			total_q <= total_d;
		end
	end

endmodule

>>> hw/rtl/debounced_pulse_burst_counter.sv
// Top level of the debounced pulse burst counter.
// Input register, edge engine and result register. Depends on dpbc_pkg, dpbc_cfg, dpbc_engine.
//
// Each item is an edge event (mode 0) or a status query (mode 1) with a ms timestamp.
// The block debounces falling edges against min_pulse_width, groups pulses into runs
// split by gaps longer than max_pulse_gap, and returns one status item per input item:
// total pulse count, current run count and current high width. An item is latched in
// the input register, processed combinationally by the engine and lands in the result
// register once that register is empty or being drained, which raises out_valid; one item
// can be taken every cycle while out_stall is low; the engine state update is the only
// per-item work. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
module debounced_pulse_burst_counter
	import dpbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic              pin_level,
	input  logic [TIME_W-1:0] now_ms,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CNT_W-1:0]  total_pulses,
	output logic [CNT_W-1:0]  run_pulses,
	output logic [TIME_W-1:0] high_width_ms
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_take;

	dpbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held item moves on when the result register is empty or being drained
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode <= mode;
			item_s1.pin_level <= pin_level;
			item_s1.now_ms <= now_ms;
		end
	end

	// engine state commits only when the item moves into the result register
	dpbc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_comb;
	end

	assign out_valid = valid_s2;
	assign total_pulses = res_s2.total_pulses;
	assign run_pulses = res_s2.run_pulses;
	assign high_width_ms = res_s2.high_width_ms;

endmodule

>>> tb/sv/tb_debounced_pulse_burst_counter.sv
// Self-checking testbench for debounced_pulse_burst_counter.
// A queue-fed driver, a monitor and an in-bench model of the debounce and run logic.
// Depends on dpbc_pkg and the debounced_pulse_burst_counter RTL.
module tb_debounced_pulse_burst_counter;
	import dpbc_pkg::*;

	// Cycles with no item moving on either channel before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// Items per random burst; five bursts plus the directed list give about 2000 items
	localparam int BURST_ITEMS = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_MIN_PULSE_WIDTH;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              mode = MODE_EDGE;
	logic              pin_level = 1'b0;
	logic [TIME_W-1:0] now_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CNT_W-1:0]  total_pulses;
	logic [CNT_W-1:0]  run_pulses;
	logic [TIME_W-1:0] high_width_ms;

	debounced_pulse_burst_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.pin_level     (pin_level),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.total_pulses  (total_pulses),
		.run_pulses    (run_pulses),
		.high_width_ms (high_width_ms)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Model of the block: register copy and pin-tracking state.
	// Pin state is updated only when an item is taken; set_cfg updates the register copy.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0]  min_width_ms = MIN_PULSE_WIDTH_RST;
	logic [CFG_W-1:0]  max_gap_ms = MAX_PULSE_GAP_RST;
	logic              seen_rise = 1'b0;     // last processed edge was rising
	logic [TIME_W-1:0] edge_ms = '0;         // time of last edge (or pulse end after a bounce)
	logic [TIME_W-1:0] pulse_end_ms = '0;    // time of last accepted falling edge
	logic [CNT_W-1:0]  run_cnt = '0;
	logic [CNT_W-1:0]  total_cnt = '0;

	// Apply one item to the model and return the status the block must report
	function automatic result_t debounce_step(item_t it);
		logic [TIME_W-1:0] span;
		result_t           st;
		if (it.mode == MODE_EDGE && it.pin_level != seen_rise) begin
			span = it.now_ms - edge_ms;
			if (it.pin_level) begin
				// low gap too long: a new run starts
				if (span > TIME_W'(max_gap_ms))
					run_cnt = '0;
				edge_ms = it.now_ms;
			end else if (span < TIME_W'(min_width_ms)) begin
				// bounce: forget the short high, fall back to the last real pulse end
				edge_ms = pulse_end_ms;
			end else begin
				run_cnt = run_cnt + 1'b1;
				total_cnt = total_cnt + 1'b1;
				edge_ms = it.now_ms;
				pulse_end_ms = it.now_ms;
			end
			seen_rise = it.pin_level;
		end
		span = it.now_ms - edge_ms;
		st.total_pulses = total_cnt;
		st.run_pulses = (!seen_rise && span > TIME_W'(max_gap_ms)) ? '0 : run_cnt;
		st.high_width_ms = (seen_rise && span >= TIME_W'(min_width_ms)) ? span : '0;
		return st;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping. The feed is filled at the falling edge and drained
	// at the rising edge; the result counter the sequencer polls is NBA-updated.
	// ------------------------------------------------------------------
	item_t       sample_feed[$];   // items still to be presented
	result_t     due_status[$];    // predicted status, oldest first
	int unsigned issued_cnt = 0;   // items put on the feed
	int unsigned checked_cnt = 0;  // results taken off the output channel
	int unsigned mismatch_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned quiet_cycles = 0;

	// ------------------------------------------------------------------
	// Driver: predicts each item as it is taken, then presents the next one
	// or idles. A stalled item stays on the pins untouched.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				due_status.push_back(debounce_step(item_t'{mode, pin_level, now_ms}));
			if (!in_valid || !in_stall) begin
				if (sample_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = sample_feed.pop_front();
					in_valid <= 1'b1;
					mode <= nxt.mode;
					pin_level <= nxt.pin_level;
					now_ms <= nxt.now_ms;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks every taken result against the oldest prediction,
	// and throttles the output channel.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_status.size() == 0) begin
					$error("status item with nothing predicted: total %0d run %0d width %0d",
						total_pulses, run_pulses, high_width_ms);
					mismatch_cnt++;
				end else begin
					want = due_status.pop_front();
					if (total_pulses !== want.total_pulses) begin
						$error("total_pulses: expected %0d, got %0d",
							want.total_pulses, total_pulses);
						mismatch_cnt++;
					end
					if (run_pulses !== want.run_pulses) begin
						$error("run_pulses: expected %0d, got %0d", want.run_pulses, run_pulses);
						mismatch_cnt++;
					end
					if (high_width_ms !== want.high_width_ms) begin
						$error("high_width_ms: expected %0d, got %0d",
							want.high_width_ms, high_width_ms);
						mismatch_cnt++;
					end
				end
				checked_cnt <= checked_cnt + 1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Hang detection: nothing moving on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb_debounced_pulse_burst_counter: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer helpers
	// ------------------------------------------------------------------
	logic              gen_lvl = 1'b0;  // level of the last generated edge
	logic [TIME_W-1:0] gen_ms = '0;     // timestamp of the last generated item

	function automatic void queue_item(logic m, logic lvl, logic [TIME_W-1:0] t);
		sample_feed.push_back(item_t'{m, lvl, t});
		issued_cnt++;
		gen_ms = t;
		if (m == MODE_EDGE)
			gen_lvl = lvl;
	endfunction

	// Time step biased toward the min-width and max-gap thresholds; the
	// off-by-two steps can go negative, which wraps the timestamp.
	function automatic logic [TIME_W-1:0] pick_step();
		logic [TIME_W-1:0] d;
		case ($urandom_range(9))
			0, 1: d = $urandom_range(int'(min_width_ms) + 2);
			2, 3: d = int'(min_width_ms) + int'($urandom_range(4)) - 2;
			4, 5: d = int'(max_gap_ms) + int'($urandom_range(4)) - 2;
			6, 7: d = $urandom_range(int'(min_width_ms) + int'(max_gap_ms) + 8);
			8: d = $urandom_range(200000);
			default: d = $urandom();
		endcase
		return d;
	endfunction

	// Wait until every item issued so far has come back
	task automatic settle();
		do @(negedge clk); while (checked_cnt != issued_cnt);
	endtask

	// Both registers, written only while the block is idle
	task automatic set_cfg(logic [CFG_W-1:0] min_w, logic [CFG_W-1:0] max_g);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_PULSE_WIDTH;
		cfg_data <= min_w;
		@(posedge clk);
		cfg_index <= CFG_MAX_PULSE_GAP;
		cfg_data <= max_g;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_width_ms = min_w;
		max_gap_ms = max_g;
	endtask

	// Mostly clean alternating edges with thresholds in reach, plus repeated
	// levels, queries, and fully random noise items.
	task automatic random_burst(int n, int unsigned idle, int unsigned stall);
		int unsigned k;
		@(negedge clk);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			k = $urandom_range(99);
			if (k < 70)
				queue_item(MODE_EDGE, !gen_lvl, gen_ms + pick_step());
			else if (k < 80)
				queue_item(MODE_EDGE, gen_lvl, gen_ms + pick_step());
			else if (k < 95)
				queue_item(MODE_QUERY, 1'($urandom_range(1)), gen_ms + pick_step());
			else
				queue_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed list at reset config (min width 10, max gap 500)
		@(negedge clk);
		queue_item(MODE_QUERY, 1'b0, 32'd0);          // fresh state
		queue_item(MODE_QUERY, 1'b1, 32'hFFFF_FFFF);  // query ignores level, max stamp
		queue_item(MODE_EDGE, 1'b0, 32'd50);          // repeated low level: no change
		queue_item(MODE_EDGE, 1'b1, 32'd100);         // rise inside the gap
		queue_item(MODE_QUERY, 1'b0, 32'd105);        // high but below min width
		queue_item(MODE_QUERY, 1'b0, 32'd110);        // high exactly at min width
		queue_item(MODE_EDGE, 1'b1, 32'd120);         // repeated high level
		queue_item(MODE_EDGE, 1'b0, 32'd104);         // bounce, back to pulse end 0
		queue_item(MODE_QUERY, 1'b0, 32'd200);
		queue_item(MODE_EDGE, 1'b1, 32'd300);
		queue_item(MODE_EDGE, 1'b0, 32'd350);         // first real pulse
		queue_item(MODE_EDGE, 1'b1, 32'd400);
		queue_item(MODE_EDGE, 1'b0, 32'd409);         // bounce, back to 350
		queue_item(MODE_QUERY, 1'b0, 32'd850);        // gap exactly at max: run kept
		queue_item(MODE_QUERY, 1'b0, 32'd851);        // one past max: run reads zero
		queue_item(MODE_EDGE, 1'b1, 32'd850);         // rise at max gap keeps the run
		queue_item(MODE_EDGE, 1'b0, 32'd860);         // pulse exactly min width counts
		queue_item(MODE_EDGE, 1'b1, 32'd1361);        // rise past max gap clears the run
		queue_item(MODE_QUERY, 1'b1, 32'd1361);
		queue_item(MODE_EDGE, 1'b0, 32'd1400);
		queue_item(MODE_EDGE, 1'b1, 32'hFFFF_FFF8);   // rise just before the wrap
		queue_item(MODE_QUERY, 1'b0, 32'h0000_0005);  // width across the wrap
		queue_item(MODE_EDGE, 1'b0, 32'h0000_0008);   // pulse across the wrap counts
		queue_item(MODE_QUERY, 1'b1, 32'hFFFF_FFFF);  // backward stamp wraps to huge gap
		settle();

		// Random bursts: each idling profile paired with a different register setting
		random_burst(BURST_ITEMS, 0, 0);
		set_cfg('0, '0);
		random_burst(BURST_ITEMS, 83, 0);
		set_cfg('1, '1);
		random_burst(BURST_ITEMS, 0, 83);
		set_cfg(CFG_W'($urandom_range(40)), CFG_W'($urandom_range(300)));
		random_burst(BURST_ITEMS, 29, 29);
		set_cfg(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)));
		random_burst(BURST_ITEMS, 0, 0);

		// Allow a stray extra result to surface before the verdict
		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0 && due_status.size() == 0) begin
			$display("tb_debounced_pulse_burst_counter: clean");
		end else begin
			$display("tb_debounced_pulse_burst_counter: errors");
		end
		$finish;
	end

endmodule
